/* design/tcw_pkg.sv */
// Package for the text console writer: item kinds, character codes,
// field widths, cursor unit operations and sequencer states.
// Used by every module of the block; it depends on nothing.
package tcw_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned CELL_W   = CHAR_W + ATTR_W;
  localparam int unsigned RADDR_W  = 11;
  localparam int unsigned COL_OUT_W = 7;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned OFF_OUT_W = 11;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_BACK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CUR_HOLD    = 3'd0,
    CUR_ADVANCE = 3'd1,
    CUR_NEWLINE = 3'd2,
    CUR_BACK    = 3'd3,
    CUR_HOME    = 3'd4
  } cur_op_e;

  typedef struct packed {
    logic scroll;
    logic moved;
  } cur_flags_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_FILL   = 10'b00_0000_0010,
    ST_PUT    = 10'b00_0000_0100,
    ST_SCR_RD = 10'b00_0000_1000,
    ST_SCR_WR = 10'b00_0001_0000,
    ST_BACK   = 10'b00_0010_0000,
    ST_BLANK  = 10'b00_0100_0000,
    ST_RD_ADR = 10'b00_1000_0000,
    ST_RD_DAT = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_e;

endpackage

/* design/tcw_screen_ram.sv */
// Screen cell memory: one write port and one read port with registered
// read data. Depends on tcw_pkg for the cell width.
module tcw_screen_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tcw_cursor_unit.sv */
// Cursor step unit: advance, new line, step back and home, with wrap and
// scroll detection. Depends on tcw_pkg for operation codes and flags.
module tcw_cursor_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned COL_W   = 7,
  parameter int unsigned ROW_W   = 5,
  parameter int unsigned OFF_W   = 11
) (
  input  tcw_pkg::cur_op_e    op_i,
  input  logic [COL_W-1:0]    col_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [OFF_W-1:0]    off_i,
  output logic [COL_W-1:0]    col_o,
  output logic [ROW_W-1:0]    row_o,
  output logic [OFF_W-1:0]    off_o,
  output tcw_pkg::cur_flags_t flags_o
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL     = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [OFF_W-1:0] LAST_ROW_OFF = OFF_W'((ROWS - 1) * COLUMNS);
  localparam logic [OFF_W-1:0] COLS_OFF     = OFF_W'(COLUMNS);

  logic at_last_col;
  logic at_last_row;

  assign at_last_col = (col_i == LAST_COL);
  assign at_last_row = (row_i == LAST_ROW);

  always_comb begin
    col_o   = col_i;
    row_o   = row_i;
    off_o   = off_i;
    flags_o = '0;
    unique case (op_i)
      CUR_ADVANCE: begin
        if (!at_last_col) begin
          col_o = col_i + COL_W'(1);
          off_o = off_i + OFF_W'(1);
        end else if (!at_last_row) begin
          col_o = '0;
          row_o = row_i + ROW_W'(1);
          off_o = off_i + OFF_W'(1);
        end else begin
          col_o          = '0;
          row_o          = LAST_ROW;
          off_o          = LAST_ROW_OFF;
          flags_o.scroll = 1'b1;
        end
      end
      CUR_NEWLINE: begin
        col_o = '0;
        if (!at_last_row) begin
          row_o = row_i + ROW_W'(1);
          off_o = off_i - OFF_W'(col_i) + COLS_OFF;
        end else begin
          row_o          = LAST_ROW;
          off_o          = LAST_ROW_OFF;
          flags_o.scroll = 1'b1;
        end
      end
      CUR_BACK: begin
        if (col_i != '0) begin
          col_o         = col_i - COL_W'(1);
          off_o         = off_i - OFF_W'(1);
          flags_o.moved = 1'b1;
        end else if (row_i != '0) begin
          col_o         = LAST_COL;
          row_o         = row_i - ROW_W'(1);
          off_o         = off_i - OFF_W'(1);
          flags_o.moved = 1'b1;
        end
      end
      CUR_HOME: begin
        col_o = '0;
        row_o = '0;
        off_o = '0;
      end
      CUR_HOLD: begin
        col_o = col_i;
      end
      default: begin
        col_o = col_i;
      end
    endcase
  end

endmodule

/* design/text_console_writer_core.sv */
// Text console writer top level: sequencer, cursor registers and result
// register around tcw_cursor_unit and tcw_screen_ram. Depends on tcw_pkg.
//
//   channel   direction  handshake                    payload
//   in        sink       in_valid_i / in_ready_o      kind, char_code, read_address
//   out       source     out_valid_o / out_ready_i    cursor_col/row/offset, read_char/attr
//   cfg       sink       cfg_we_i                     cfg_data_i (text attribute)
//
// A tab writes a blank into each of its TAB_WIDTH cells. A scroll reads then writes each cell
// through the one port pair, and a clear writes a blank into every cell. After reset the block
// fills the screen with in_ready_o low. A stalled output holds the finished item in the
// result register; the next item is accepted meanwhile and waits in its last state.
module text_console_writer_core #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::KIND_W-1:0]    kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::RADDR_W-1:0]   read_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::COL_OUT_W-1:0] cursor_col_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row_o,
  output logic [tcw_pkg::OFF_OUT_W-1:0] cursor_offset_o,
  output logic [tcw_pkg::CHAR_W-1:0]    read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]    read_attr_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS      = COLUMNS * ROWS;
  localparam int unsigned MOVE_CELLS = (ROWS - 1) * COLUMNS;
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned AW         = $clog2(CELLS);
  localparam int unsigned TW         = $clog2(TAB_WIDTH + 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [AW-1:0]       off_q, off_d;
  logic [ATTR_W-1:0]   attr_q, attr_d;
  logic [ATTR_W-1:0]   fill_attr_q, fill_attr_d;
  logic                fill_item_q, fill_item_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                is_nl_q, is_nl_d;
  logic [TW-1:0]       tab_left_q, tab_left_d;
  logic [RADDR_W-1:0]  rd_addr_q, rd_addr_d;
  logic                in_range_q, in_range_d;
  logic [CHAR_W-1:0]   res_char_q, res_char_d;
  logic [ATTR_W-1:0]   res_attr_q, res_attr_d;
  logic                out_valid_q, out_valid_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;
  logic [AW-1:0]       out_off_q, out_off_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic [ATTR_W-1:0]   out_attr_q, out_attr_d;

  cur_op_e             cur_op;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [AW-1:0]       cur_off;
  cur_flags_t          cur_flags;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  logic                in_accept;
  logic                out_free;
  logic                scr_move;
  kind_e               kind;

  tcw_cursor_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .COL_W  (COL_W),
    .ROW_W  (ROW_W),
    .OFF_W  (AW)
  ) u_cursor (
    .op_i   (cur_op),
    .col_i  (col_q),
    .row_i  (row_q),
    .off_i  (off_q),
    .col_o  (cur_col),
    .row_o  (cur_row),
    .off_o  (cur_off),
    .flags_o(cur_flags)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .ADDR_W(AW)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign scr_move   = (32'(cnt_q) < MOVE_CELLS);
  assign kind       = kind_e'(kind_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    off_d       = off_q;
    attr_d      = cfg_we_i ? cfg_data_i : attr_q;
    fill_attr_d = fill_attr_q;
    fill_item_d = fill_item_q;
    char_d      = char_q;
    is_nl_d     = is_nl_q;
    tab_left_d  = tab_left_q;
    rd_addr_d   = rd_addr_q;
    in_range_d  = in_range_q;
    res_char_d  = res_char_q;
    res_attr_d  = res_attr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_off_d   = out_off_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    cur_op      = CUR_HOLD;
    mem_we      = 1'b0;
    mem_waddr   = off_q;
    mem_wdata   = {attr_q, char_q};
    mem_raddr   = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_char_d = '0;
          res_attr_d = '0;
          is_nl_d    = 1'b0;
          unique case (kind)
            KIND_PUT: begin
              char_d     = char_code_i;
              tab_left_d = TW'(1);
              state_d    = ST_PUT;
              if (char_code_i == CHAR_NUL) begin
                state_d = ST_FINISH;
              end else if (char_code_i == CHAR_LF || char_code_i == CHAR_CR) begin
                is_nl_d    = 1'b1;
                tab_left_d = '0;
              end else if (char_code_i == CHAR_TAB) begin
                char_d     = CHAR_BLANK;
                tab_left_d = TW'(TAB_WIDTH);
              end
            end
            KIND_BACK: begin
              state_d = ST_BACK;
            end
            KIND_CLEAR: begin
              cur_op      = CUR_HOME;
              col_d       = cur_col;
              row_d       = cur_row;
              off_d       = cur_off;
              fill_attr_d = attr_q;
              fill_item_d = 1'b1;
              cnt_d       = '0;
              state_d     = ST_FILL;
            end
            KIND_READ: begin
              rd_addr_d  = read_address_i;
              in_range_d = (32'(read_address_i) < CELLS);
              state_d    = ST_RD_ADR;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {fill_attr_q, CHAR_BLANK};
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = fill_item_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_PUT: begin
        if (is_nl_q) begin
          cur_op = CUR_NEWLINE;
        end else begin
          cur_op     = CUR_ADVANCE;
          mem_we     = 1'b1;
          tab_left_d = tab_left_q - TW'(1);
        end
        col_d = cur_col;
        row_d = cur_row;
        off_d = cur_off;
        if (cur_flags.scroll) begin
          cnt_d   = '0;
          state_d = ST_SCR_RD;
        end else if (tab_left_d != '0) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCR_RD: begin
        mem_raddr = scr_move ? (cnt_q + AW'(COLUMNS)) : cnt_q;
        state_d   = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = scr_move ? mem_rdata : {mem_rdata[CELL_W-1:CHAR_W], CHAR_BLANK};
        cnt_d     = cnt_q + AW'(1);
        state_d   = ST_SCR_RD;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = (tab_left_q != '0) ? ST_PUT : ST_FINISH;
        end
      end
      ST_BACK: begin
        cur_op  = CUR_BACK;
        col_d   = cur_col;
        row_d   = cur_row;
        off_d   = cur_off;
        state_d = cur_flags.moved ? ST_BLANK : ST_FINISH;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_q, CHAR_BLANK};
        state_d   = ST_FINISH;
      end
      ST_RD_ADR: begin
        mem_raddr = AW'(rd_addr_q);
        state_d   = ST_RD_DAT;
      end
      ST_RD_DAT: begin
        if (in_range_q) begin
          res_char_d = mem_rdata[CHAR_W-1:0];
          res_attr_d = mem_rdata[CELL_W-1:CHAR_W];
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_col_d   = col_q;
          out_row_d   = row_q;
          out_off_d   = off_q;
          out_char_d  = res_char_q;
          out_attr_d  = res_attr_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      off_q       <= '0;
      attr_q      <= RESET_ATTR;
      fill_attr_q <= RESET_ATTR;
      fill_item_q <= 1'b0;
      tab_left_q  <= '0;
      is_nl_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      off_q       <= off_d;
      attr_q      <= attr_d;
      fill_attr_q <= fill_attr_d;
      fill_item_q <= fill_item_d;
      tab_left_q  <= tab_left_d;
      is_nl_q     <= is_nl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    rd_addr_q  <= rd_addr_d;
    in_range_q <= in_range_d;
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_off_q  <= out_off_d;
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = COL_OUT_W'(out_col_q);
  assign cursor_row_o    = ROW_OUT_W'(out_row_q);
  assign cursor_offset_o = OFF_OUT_W'(out_off_q);
  assign read_char_o     = out_char_q;
  assign read_attr_o     = out_attr_q;

  // The cursor always lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor left the screen");

  // The linear offset tracks row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(off_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("cursor offset out of step with row and column");

  // The screen is never written while the block waits for an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("screen written while idle");

  // A finished item reaches the result register once it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished item not presented");

endmodule

/* tb/tb.sv */
// Self-checking testbench for text_console_writer_core: a screen and cursor predictor checks
// every result, with random idling on both channels and output back-pressure.
// Depends on tcw_pkg and on the design under test.
module tb;
  import tcw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_WIDTH     = 4;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS  = 1440;
  localparam int RANDOM_PHASES = 6;
  localparam int SCROLL_BUDGET = 50;
  localparam int LIMIT_CYCLES  = 5000000;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [OFF_OUT_W-1:0] offset;
    logic [CHAR_W-1:0]    rchar;
    logic [ATTR_W-1:0]    rattr;
  } cursor_report_t;

  typedef enum {BURST_TEXT, BURST_EDIT, BURST_READ, BURST_CLEAR, BURST_NOISE} burst_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [ATTR_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [RADDR_W-1:0]   read_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [COL_OUT_W-1:0] cursor_col_o;
  logic [ROW_OUT_W-1:0] cursor_row_o;
  logic [OFF_OUT_W-1:0] cursor_offset_o;
  logic [CHAR_W-1:0]    read_char_o;
  logic [ATTR_W-1:0]    read_attr_o;

  logic [CELL_W-1:0] screen_model [0:CELLS-1];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] text_attr;

  cursor_report_t pending_reports[$];
  bit             steady = 1'b0;
  int             hold_cycles = 0;
  int             error_count = 0;
  int             items_sent = 0;
  int             scroll_count = 0;
  int             clear_count = 0;
  int             read_count = 0;
  int             attr_writes = 0;

  text_console_writer_core #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .read_address_i (read_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_offset_o(cursor_offset_o),
    .read_char_o    (read_char_o),
    .read_attr_o    (read_attr_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
      screen_model[i] = screen_model[i + COLUMNS];
    end
    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
      screen_model[i][CHAR_W-1:0] = CHAR_BLANK;
    end
    cur_row = ROWS - 1;
    cur_col = 0;
    scroll_count++;
  endfunction

  function automatic void print_cell(logic [CHAR_W-1:0] ch);
    screen_model[cur_row * COLUMNS + cur_col] = {text_attr, ch};
    cur_col++;
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      scroll_screen();
    end
  endfunction

  function automatic cursor_report_t predict_report(kind_e k, logic [CHAR_W-1:0] ch,
                                                    logic [RADDR_W-1:0] addr);
    cursor_report_t rep;
    rep = '0;
    case (k)
      KIND_PUT: begin
        if (ch == CHAR_LF || ch == CHAR_CR) begin
          cur_row++;
          cur_col = 0;
          if (cur_row >= ROWS) begin
            scroll_screen();
          end
        end else if (ch == CHAR_TAB) begin
          for (int i = 0; i < TAB_WIDTH; i++) begin
            print_cell(CHAR_BLANK);
          end
        end else if (ch != CHAR_NUL) begin
          print_cell(ch);
        end
      end
      KIND_BACK: begin
        if (cur_col > 0 || cur_row > 0) begin
          if (cur_col > 0) begin
            cur_col--;
          end else begin
            cur_col = COLUMNS - 1;
            cur_row--;
          end
          screen_model[cur_row * COLUMNS + cur_col] = {text_attr, CHAR_BLANK};
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = {text_attr, CHAR_BLANK};
        end
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      default: begin
        read_count++;
        if (addr < CELLS) begin
          rep.rchar = screen_model[addr][CHAR_W-1:0];
          rep.rattr = screen_model[addr][CELL_W-1:CHAR_W];
        end
      end
    endcase
    rep.col    = cur_col[COL_OUT_W-1:0];
    rep.row    = cur_row[ROW_OUT_W-1:0];
    rep.offset = OFF_OUT_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < PRINT_CAP) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
    error_count++;
  endtask

  task automatic send_item(kind_e k, logic [CHAR_W-1:0] ch, logic [RADDR_W-1:0] addr);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    char_code_i    <= ch;
    read_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_reports.push_back(predict_report(k, ch, addr));
    items_sent++;
  endtask

  task automatic wait_all_reported();
    in_valid_i <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk_i);
  endtask

  task automatic set_attribute(logic [ATTR_W-1:0] value);
    wait_all_reported();
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    text_attr = value;
    attr_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Results are taken on the pre-edge values; ready for the next cycle is decided here.
  always @(posedge clk_i) begin
    cursor_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing expected, cursor offset", cursor_offset_o, 0);
      end else begin
        want = pending_reports.pop_front();
        if (cursor_col_o != want.col) report_mismatch("cursor_col", cursor_col_o, want.col);
        if (cursor_row_o != want.row) report_mismatch("cursor_row", cursor_row_o, want.row);
        if (cursor_offset_o != want.offset) begin
          report_mismatch("cursor_offset", cursor_offset_o, want.offset);
        end
        if (read_char_o != want.rchar) report_mismatch("read_char", read_char_o, want.rchar);
        if (read_attr_o != want.rattr) report_mismatch("read_attr", read_attr_o, want.rattr);
      end
    end
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 25);
    end
  end

  task automatic test_reset_contents();
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, 11'd1999);
    send_item(KIND_READ, 8'h00, 11'd2000);
    send_item(KIND_READ, 8'h00, 11'd2047);
    send_item(KIND_READ, 8'h00, 11'd1024);
  endtask

  task automatic test_put_codes();
    send_item(KIND_PUT, 8'h41, 11'd0);
    send_item(KIND_PUT, CHAR_NUL, 11'd2047);
    send_item(KIND_PUT, 8'hFF, 11'd0);
    send_item(KIND_PUT, CHAR_TAB, 11'd0);
    send_item(KIND_PUT, CHAR_CR, 11'd0);
    send_item(KIND_PUT, 8'h62, 11'd0);
    send_item(KIND_PUT, CHAR_LF, 11'd0);
    send_item(KIND_PUT, 8'h7F, 11'd0);
  endtask

  task automatic test_backspace();
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd159);
    send_item(KIND_CLEAR, 8'h00, 11'd0);
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd0);
  endtask

  task automatic test_attribute();
    set_attribute(8'h00);
    send_item(KIND_PUT, 8'h78, 11'd0);
    set_attribute(8'hFF);
    send_item(KIND_PUT, 8'h79, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd1);
  endtask

  task automatic test_scroll_and_wrap();
    set_attribute(8'h1E);
    send_item(KIND_CLEAR, 8'h00, 11'd0);
    repeat (COLUMNS - 3) send_item(KIND_PUT, 8'($urandom_range(8'h21, 8'h7E)), 11'd0);
    send_item(KIND_PUT, CHAR_TAB, 11'd0);
    send_item(KIND_READ, 8'h00, 11'(COLUMNS - 1));
    send_item(KIND_READ, 8'h00, 11'(COLUMNS));
    while (cur_row < ROWS - 1) send_item(KIND_PUT, CHAR_LF, 11'd0);
    send_item(KIND_PUT, 8'h5A, 11'd0);
    set_attribute(8'hA5);
    send_item(KIND_PUT, CHAR_LF, 11'd0);
    send_item(KIND_READ, 8'h00, 11'((ROWS - 1) * COLUMNS));
    send_item(KIND_READ, 8'h00, 11'((ROWS - 2) * COLUMNS));
    send_item(KIND_READ, 8'h00, 11'd0);
    repeat (COLUMNS) send_item(KIND_PUT, 8'($urandom_range(8'h21, 8'hFE)), 11'd0);
    repeat (COLUMNS - 2) send_item(KIND_PUT, 8'($urandom_range(8'h21, 8'h7E)), 11'd0);
    send_item(KIND_PUT, CHAR_TAB, 11'd0);
    send_item(KIND_READ, 8'h00, 11'((ROWS - 2) * COLUMNS + COLUMNS - 1));
    send_item(KIND_READ, 8'h00, 11'((ROWS - 1) * COLUMNS + 1));
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_BACK, 8'h00, 11'd0);
    send_item(KIND_PUT, CHAR_CR, 11'd0);
    send_item(KIND_READ, 8'h00, 11'(CELLS - 1));
  endtask

  task automatic test_output_backpressure();
    wait_all_reported();
    steady = 1'b1;
    hold_cycles = 600;
    repeat (40) send_item(KIND_PUT, 8'($urandom_range(8'h21, 8'h7E)), 11'd0);
    steady = 1'b0;
    wait_all_reported();
    repeat (5) send_item(KIND_READ, 8'h00, 11'($urandom_range(CELLS - 1)));
  endtask

  task automatic test_random_traffic();
    burst_e             mode;
    int                 burst_len;
    int                 left;
    int                 pick;
    int                 near;
    kind_e              k;
    logic [CHAR_W-1:0]  ch;
    logic [RADDR_W-1:0] addr;
    mode = BURST_TEXT;
    burst_len = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) set_attribute(8'hFF);
      else if (phase == 1) set_attribute(8'h00);
      else set_attribute(8'($urandom_range(255)));
      steady = (phase == 3);
      left = RANDOM_ITEMS / RANDOM_PHASES;
      while (left > 0) begin
        if (burst_len == 0) begin
          pick = $urandom_range(99);
          if (pick < 60) begin
            mode = BURST_TEXT;
            burst_len = $urandom_range(1, 90);
          end else if (pick < 72) begin
            mode = BURST_EDIT;
            burst_len = $urandom_range(1, 8);
          end else if (pick < 87) begin
            mode = BURST_READ;
            burst_len = $urandom_range(1, 6);
          end else if (pick < 91) begin
            mode = BURST_CLEAR;
            burst_len = 1;
          end else begin
            mode = BURST_NOISE;
            burst_len = $urandom_range(1, 4);
          end
        end
        ch   = 8'($urandom_range(255));
        addr = 11'($urandom_range(2047));
        case (mode)
          BURST_TEXT: begin
            k = KIND_PUT;
            pick = $urandom_range(99);
            if (burst_len == 1) ch = pick < 50 ? CHAR_LF : CHAR_CR;
            else if (pick < 5) ch = CHAR_TAB;
            else if (pick < 8) ch = CHAR_NUL;
            else if (pick >= 20) ch = 8'($urandom_range(8'h20, 8'h7E));
          end
          BURST_EDIT: k = KIND_BACK;
          BURST_READ: begin
            k = KIND_READ;
            near = cur_row * COLUMNS + cur_col;
            if ($urandom_range(1) == 1) begin
              addr = 11'(near >= 90 ? near - $urandom_range(0, 90) : near);
            end
          end
          BURST_CLEAR: k = KIND_CLEAR;
          default: k = kind_e'($urandom_range(3));
        endcase
        burst_len--;
        if (k == KIND_PUT && scroll_count >= SCROLL_BUDGET && cur_row == ROWS - 1) begin
          send_item(KIND_CLEAR, ch, addr);
        end
        send_item(k, ch, addr);
        left--;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = {RESET_ATTR, CHAR_BLANK};
    end
    cur_col = 0;
    cur_row = 0;
    text_attr = RESET_ATTR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_contents();
    test_put_codes();
    test_backspace();
    test_attribute();
    test_scroll_and_wrap();
    test_output_backpressure();
    test_random_traffic();
    wait_all_reported();
    repeat (50) @(posedge clk_i);
    if (pending_reports.size() > 0) begin
      report_mismatch("results never delivered", 0, pending_reports.size());
    end
    $display("Ran %0d items with %0d scrolls, %0d clears and %0d cell reads,",
             items_sent, scroll_count, clear_count, read_count);
    $display("under %0d attribute settings; %0d mismatches.", attr_writes, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Timeout: %0d results still outstanding.", pending_reports.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
